// ===== hw/rtl/sic_instruction_execute_defines.svh =====
// Assertion macros for the SIC core RTL.
`ifndef SIC_INSTRUCTION_EXECUTE_DEFINES_SVH
`define SIC_INSTRUCTION_EXECUTE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SIC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sic_pkg.sv =====
// Shared types and constants for the SIC core.
package sic_pkg;

    localparam int ADDR_BITS = 15;
    localparam int WORD_BITS = 24;
    localparam int STEP_BITS = $clog2(WORD_BITS);

    // Command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_EXEC  = 2'd2;

    // Condition codes
    localparam logic [1:0] CC_LT = 2'd0;
    localparam logic [1:0] CC_EQ = 2'd1;
    localparam logic [1:0] CC_GT = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DIV0  = 2'd1;
    localparam logic [1:0] ST_BADOP = 2'd2;

    // Opcodes
    localparam logic [7:0] OP_LDA  = 8'h00;
    localparam logic [7:0] OP_LDX  = 8'h04;
    localparam logic [7:0] OP_LDL  = 8'h08;
    localparam logic [7:0] OP_STA  = 8'h0C;
    localparam logic [7:0] OP_STX  = 8'h10;
    localparam logic [7:0] OP_STL  = 8'h14;
    localparam logic [7:0] OP_ADD  = 8'h18;
    localparam logic [7:0] OP_SUB  = 8'h1C;
    localparam logic [7:0] OP_MUL  = 8'h20;
    localparam logic [7:0] OP_DIV  = 8'h24;
    localparam logic [7:0] OP_COMP = 8'h28;
    localparam logic [7:0] OP_TIX  = 8'h2C;
    localparam logic [7:0] OP_JEQ  = 8'h30;
    localparam logic [7:0] OP_JGT  = 8'h34;
    localparam logic [7:0] OP_JLT  = 8'h38;
    localparam logic [7:0] OP_J    = 8'h3C;
    localparam logic [7:0] OP_AND  = 8'h40;
    localparam logic [7:0] OP_OR   = 8'h44;
    localparam logic [7:0] OP_JSUB = 8'h48;
    localparam logic [7:0] OP_RSUB = 8'h4C;
    localparam logic [7:0] OP_LDCH = 8'h50;
    localparam logic [7:0] OP_STCH = 8'h54;
    localparam logic [7:0] OP_STSW = 8'hE8;

    // Request from the sequencer to the multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } alu_req_t;

endpackage

// ===== hw/rtl/sic_alu.sv =====
// Iterative 24-bit multiply and signed divide unit, one bit per cycle.
module sic_alu (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sic_pkg::alu_req_t              req,
    input  logic [sic_pkg::WORD_BITS-1:0]  opa,
    input  logic [sic_pkg::WORD_BITS-1:0]  opb,
    output logic                           done,
    output logic [sic_pkg::WORD_BITS-1:0]  result
);
    import sic_pkg::*;

    logic                 running_reg;
    logic                 done_reg;
    logic                 div_reg;
    logic                 neg_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic [WORD_BITS-1:0] acc_reg;   // product, or quotient bits shifting in
    logic [WORD_BITS-1:0] opa_reg;   // multiplicand, or dividend magnitude
    logic [WORD_BITS-1:0] opb_reg;   // multiplier, or divisor magnitude
    logic [WORD_BITS-1:0] rem_reg;

    logic [WORD_BITS-1:0] mag_a;
    logic [WORD_BITS-1:0] mag_b;
    logic [WORD_BITS:0]   rem_sh;
    logic [WORD_BITS:0]   rem_diff;

    // Take magnitudes of the signed operands
    assign mag_a = opa[WORD_BITS-1] ? (~opa + 1'b1) : opa;
    assign mag_b = opb[WORD_BITS-1] ? (~opb + 1'b1) : opb;

    // Shift in the next dividend bit and trial-subtract
    assign rem_sh   = {rem_reg, opa_reg[WORD_BITS-1]};
    assign rem_diff = rem_sh - {1'b0, opb_reg};

    // Control: count one step a cycle
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            step_reg    <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (req.start) begin
                running_reg <= 1'b1;
                step_reg    <= '0;
            end
            else if (running_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_BITS'(WORD_BITS - 1)) begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift-add multiply or restoring divide
    always_ff @(posedge clk) begin
        if (req.start) begin
            div_reg <= req.is_div;
            neg_reg <= opa[WORD_BITS-1] ^ opb[WORD_BITS-1];
            acc_reg <= '0;
            rem_reg <= '0;
            opa_reg <= req.is_div ? mag_a : opa;
            opb_reg <= req.is_div ? mag_b : opb;
        end
        else if (running_reg) begin
            if (div_reg) begin
                opa_reg <= {opa_reg[WORD_BITS-2:0], 1'b0};
                if (!rem_diff[WORD_BITS]) begin
                    rem_reg <= rem_diff[WORD_BITS-1:0];
                    acc_reg <= {acc_reg[WORD_BITS-2:0], 1'b1};
                end
                else begin
                    rem_reg <= rem_sh[WORD_BITS-1:0];
                    acc_reg <= {acc_reg[WORD_BITS-2:0], 1'b0};
                end
            end
            else begin
                if (opb_reg[0]) begin
                    acc_reg <= acc_reg + opa_reg;
                end
                opa_reg <= {opa_reg[WORD_BITS-2:0], 1'b0};
                opb_reg <= {1'b0, opb_reg[WORD_BITS-1:1]};
            end
        end
    end

    assign done   = done_reg;
    assign result = (div_reg && neg_reg) ? (~acc_reg + 1'b1) : acc_reg;

endmodule

// ===== hw/rtl/sic_instruction_execute.sv =====
// SIC machine core: byte memory, register file, instruction sequencer.
// One request is taken at a time and in_stall stays high until its result is
// handed off. A write, start or no-op request goes from idle straight to the
// done step. An execute request reads its instruction word through the single
// memory port in the fetch step and then decodes it; jumps and unsupported
// opcodes then go straight to the done step. Word operand loads then read 3
// bytes through the registered port and LDCH one, each followed by an execute
// step; stores write three bytes for a word and one for STCH. MUL and DIV then
// wait in the shared one-bit-per-step unit. A stalled output holds the core in
// its done step. Memory contents are not cleared at reset.
`include "sic_instruction_execute_defines.svh"
module sic_instruction_execute (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    command,
    input  logic [14:0]                   address,
    input  logic [7:0]                    data_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sic_pkg::WORD_BITS-1:0] acc,
    output logic [sic_pkg::WORD_BITS-1:0] index_reg,
    output logic [sic_pkg::WORD_BITS-1:0] link_reg,
    output logic [14:0]                   prog_counter,
    output logic [1:0]                    cond_code,
    output logic [1:0]                    status
);
    import sic_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_FETCH  = 8'b0000_0010,
        S_DECODE = 8'b0000_0100,
        S_OPER   = 8'b0000_1000,
        S_EXEC   = 8'b0001_0000,
        S_MULDIV = 8'b0010_0000,
        S_STORE  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg;

    logic [WORD_BITS-1:0] a_reg;
    logic [WORD_BITS-1:0] x_reg;
    logic [WORD_BITS-1:0] l_reg;
    logic [ADDR_BITS-1:0] pc_reg;
    logic [1:0]           cc_reg;
    logic [1:0]           st_reg;

    logic [ADDR_BITS-1:0] base_reg;
    logic [1:0]           cnt_reg;
    logic [1:0]           nbytes_reg;
    logic [WORD_BITS-1:0] sh_reg;
    logic [WORD_BITS-1:0] wdata_reg;
    logic [7:0]           opc_reg;

    logic                 out_valid_reg;
    logic [WORD_BITS-1:0] acc_out_reg;
    logic [WORD_BITS-1:0] x_out_reg;
    logic [WORD_BITS-1:0] l_out_reg;
    logic [ADDR_BITS-1:0] pc_out_reg;
    logic [1:0]           cc_out_reg;
    logic [1:0]           st_out_reg;

    logic [7:0]           mem [2**ADDR_BITS];
    logic [7:0]           mem_rdata;
    logic [ADDR_BITS-1:0] mem_addr;
    logic [7:0]           mem_wdata;
    logic                 mem_we;

    logic                 accept;
    logic                 out_free;
    logic [7:0]           dec_opc;
    logic [ADDR_BITS-1:0] dec_ta;
    logic [ADDR_BITS-1:0] pc_plus3;
    logic [1:0]           cmp_cc;
    logic [WORD_BITS-1:0] cmp_lhs;

    alu_req_t             alu_req;
    logic                 alu_done;
    logic [WORD_BITS-1:0] alu_result;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Decode the fetched instruction word
    assign dec_opc  = sh_reg[23:16];
    assign dec_ta   = sh_reg[ADDR_BITS-1:0]
                      + (sh_reg[15] ? x_reg[ADDR_BITS-1:0] : '0);
    assign pc_plus3 = pc_reg + ADDR_BITS'(3);

    // Signed compare of A or X against the operand
    assign cmp_lhs = (opc_reg == OP_TIX) ? x_reg : a_reg;
    always_comb begin
        if (cmp_lhs == sh_reg) begin
            cmp_cc = CC_EQ;
        end
        else if ($signed(cmp_lhs) > $signed(sh_reg)) begin
            cmp_cc = CC_GT;
        end
        else begin
            cmp_cc = CC_LT;
        end
    end

    // Steer the single memory port
    always_comb begin
        if (state_reg == S_IDLE) begin
            mem_addr  = address[ADDR_BITS-1:0];
            mem_wdata = data_byte;
            mem_we    = accept && (command == CMD_WRITE);
        end
        else begin
            mem_addr  = base_reg + ADDR_BITS'(cnt_reg);
            mem_wdata = wdata_reg[WORD_BITS-1:WORD_BITS-8];
            mem_we    = (state_reg == S_STORE);
        end
    end

    // Byte memory, registered read
    always_ff @(posedge clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_addr];
    end

    // Launch multiply or divide from the execute step
    always_comb begin
        alu_req.start  = (state_reg == S_EXEC)
                         && ((opc_reg == OP_MUL)
                             || ((opc_reg == OP_DIV) && (sh_reg != '0)));
        alu_req.is_div = (opc_reg == OP_DIV);
    end

    sic_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .opa    (a_reg),
        .opb    (sh_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    // Sequencer and architectural registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            a_reg         <= '0;
            x_reg         <= '0;
            l_reg         <= '0;
            pc_reg        <= '0;
            cc_reg        <= CC_EQ;
            st_reg        <= ST_OK;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (out_valid_reg && !out_stall) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        st_reg  <= ST_OK;
                        cnt_reg <= '0;
                        if (command == CMD_START) begin
                            pc_reg <= address[ADDR_BITS-1:0];
                            a_reg  <= '0;
                            x_reg  <= '0;
                            l_reg  <= '0;
                            cc_reg <= CC_LT;
                        end
                        state_reg <= (command == CMD_EXEC) ? S_FETCH : S_DONE;
                    end
                end
                S_FETCH: begin
                    // Read opcode and address field bytes
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 2'd3) begin
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    pc_reg  <= pc_plus3;
                    cnt_reg <= '0;
                    state_reg <= S_DONE;
                    unique case (dec_opc) inside
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR,
                        OP_COMP, OP_LDA, OP_LDL, OP_LDX: begin
                            state_reg <= S_OPER;
                        end
                        OP_TIX: begin
                            x_reg     <= x_reg + 1'b1;
                            state_reg <= S_OPER;
                        end
                        OP_LDCH: begin
                            state_reg <= S_OPER;
                        end
                        OP_STA, OP_STX, OP_STL, OP_STCH, OP_STSW: begin
                            state_reg <= S_STORE;
                        end
                        OP_J: begin
                            pc_reg <= dec_ta;
                        end
                        OP_JEQ: begin
                            if (cc_reg == CC_EQ) pc_reg <= dec_ta;
                        end
                        OP_JGT: begin
                            if (cc_reg == CC_GT) pc_reg <= dec_ta;
                        end
                        OP_JLT: begin
                            if (cc_reg == CC_LT) pc_reg <= dec_ta;
                        end
                        OP_JSUB: begin
                            l_reg  <= WORD_BITS'(pc_plus3);
                            pc_reg <= dec_ta;
                        end
                        OP_RSUB: begin
                            pc_reg <= l_reg[ADDR_BITS-1:0];
                        end
                        default: begin
                            st_reg <= ST_BADOP;
                        end
                    endcase
                end
                S_OPER: begin
                    // Read the operand bytes at the target address
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == nbytes_reg) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    state_reg <= S_DONE;
                    unique case (opc_reg) inside
                        OP_ADD:  a_reg <= a_reg + sh_reg;
                        OP_SUB:  a_reg <= a_reg - sh_reg;
                        OP_AND:  a_reg <= a_reg & sh_reg;
                        OP_OR:   a_reg <= a_reg | sh_reg;
                        OP_LDA:  a_reg <= sh_reg;
                        OP_LDCH: a_reg <= {a_reg[WORD_BITS-1:8], sh_reg[7:0]};
                        OP_LDL:  l_reg <= sh_reg;
                        OP_LDX:  x_reg <= sh_reg;
                        OP_COMP, OP_TIX: cc_reg <= cmp_cc;
                        OP_MUL:  state_reg <= S_MULDIV;
                        OP_DIV: begin
                            if (sh_reg == '0) begin
                                st_reg <= ST_DIV0;
                            end
                            else begin
                                state_reg <= S_MULDIV;
                            end
                        end
                        default: begin
                            st_reg <= ST_BADOP;
                        end
                    endcase
                end
                S_MULDIV: begin
                    if (alu_done) begin
                        a_reg     <= alu_result;
                        state_reg <= S_DONE;
                    end
                end
                S_STORE: begin
                    // Write one byte per cycle, most significant first
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg + 1'b1 == nbytes_reg) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers for fetch, operand and store, and the output copy
    always_ff @(posedge clk) begin
        if ((state_reg == S_FETCH || state_reg == S_OPER) && cnt_reg != 2'd0) begin
            sh_reg <= {sh_reg[WORD_BITS-9:0], mem_rdata};
        end
        if (accept) begin
            base_reg <= pc_reg;
        end
        if (state_reg == S_STORE) begin
            wdata_reg <= {wdata_reg[WORD_BITS-9:0], 8'h00};
        end
        if (state_reg == S_DECODE) begin
            base_reg   <= dec_ta;
            opc_reg    <= dec_opc;
            nbytes_reg <= (dec_opc == OP_LDCH || dec_opc == OP_STCH) ? 2'd1 : 2'd3;
            unique case (dec_opc) inside
                OP_STX:  wdata_reg <= x_reg;
                OP_STL:  wdata_reg <= l_reg;
                OP_STCH: wdata_reg <= {a_reg[7:0], 16'h0000};
                OP_STSW: wdata_reg <= WORD_BITS'(cc_reg);
                default: wdata_reg <= a_reg;
            endcase
        end
        if (state_reg == S_DONE && out_free) begin
            acc_out_reg <= a_reg;
            x_out_reg   <= x_reg;
            l_out_reg   <= l_reg;
            pc_out_reg  <= pc_reg;
            cc_out_reg  <= cc_reg;
            st_out_reg  <= st_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign acc          = acc_out_reg;
    assign index_reg    = x_out_reg;
    assign link_reg     = l_out_reg;
    assign prog_counter = 15'(pc_out_reg);
    assign cond_code    = cc_out_reg;
    assign status       = st_out_reg;

    `SIC_ASSERT_SAME(a_alu_done_state, alu_done, state_reg == S_MULDIV, "alu done outside wait")
    `SIC_ASSERT_SAME(a_mem_we_state, mem_we, state_reg == S_IDLE || state_reg == S_STORE, "stray write")
    `SIC_ASSERT_NEXT(a_done_shows, state_reg == S_DONE && out_free, out_valid_reg && state_reg == S_IDLE, "result lost")

endmodule

// ===== tb/sv/sic_instruction_execute_tb.sv =====
// Self-checking testbench for the SIC core: program loading, start and single-step execution.
module sic_instruction_execute_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sic_pkg::*;

    localparam int RAND_ITEMS  = 1150;
    localparam int IDLE_LIMIT  = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT     = 120;
    localparam int PAUSE_AT    = 260;
    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam logic [7:0] OP_RD = 8'hD8;
    localparam logic [7:0] OP_TD = 8'hE0;
    localparam logic [7:0] OP_WD = 8'hDC;

    typedef struct {
        logic [1:0]  cmd;
        logic [14:0] addr;
        logic [7:0]  data;
    } request_t;

    typedef struct {
        logic [23:0] acc;
        logic [23:0] x;
        logic [23:0] l;
        logic [14:0] pc;
        logic [1:0]  cc;
        logic [1:0]  st;
    } core_state_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = 2'd0;
    logic [14:0] address = 15'd0;
    logic [7:0]  data_byte = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [23:0] acc, index_reg, link_reg;
    logic [14:0] prog_counter;
    logic [1:0]  cond_code, status;

    sic_instruction_execute dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .address(address), .data_byte(data_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .acc(acc), .index_reg(index_reg), .link_reg(link_reg),
        .prog_counter(prog_counter), .cond_code(cond_code), .status(status)
    );

    always #6 clk = ~clk;

    // Shadow copy of the core, advanced as requests are queued
    logic [7:0]  shadow_mem [0:32767];
    bit          mem_loaded [0:32767];
    core_state_t shadow;

    request_t    request_q[$];
    core_state_t expected_q[$];
    int          total_req;
    int          sent_cnt = 0;
    int          recv_cnt = 0;
    int          errors = 0;
    int          exec_cnt = 0;
    int          hold_left = 0;
    bit          hold_done = 0;
    int          idle_cycles = 0;

    function automatic logic [23:0] word_at(logic [14:0] a);
        logic [14:0] a1, a2;
        a1 = a + 15'd1;
        a2 = a + 15'd2;
        return {shadow_mem[a], shadow_mem[a1], shadow_mem[a2]};
    endfunction

    function automatic void poke(logic [14:0] a, logic [7:0] v);
        shadow_mem[a] = v;
        mem_loaded[a] = 1'b1;
    endfunction

    function automatic void poke_word(logic [14:0] a, logic [23:0] v);
        poke(a, v[23:16]);
        poke(a + 15'd1, v[15:8]);
        poke(a + 15'd2, v[7:0]);
    endfunction

    function automatic logic [1:0] compare_words(logic [23:0] a, logic [23:0] b);
        if ($signed(a) == $signed(b))
            return CC_EQ;
        return ($signed(a) > $signed(b)) ? CC_GT : CC_LT;
    endfunction

    // Execute the instruction at PC on the shadow copy, return its status
    function automatic logic [1:0] step_instruction();
        logic [7:0]  opc;
        logic [15:0] fld;
        logic [14:0] ta;
        logic [23:0] operand;
        longint      dividend, divisor, quotient;
        opc = shadow_mem[shadow.pc];
        fld = {shadow_mem[shadow.pc + 15'd1], shadow_mem[shadow.pc + 15'd2]};
        ta = fld[14:0];
        if (fld[15])
            ta = ta + shadow.x[14:0];
        shadow.pc = shadow.pc + 15'd3;
        operand = word_at(ta);
        case (opc)
            OP_ADD:  shadow.acc = shadow.acc + operand;
            OP_SUB:  shadow.acc = shadow.acc - operand;
            OP_MUL:  shadow.acc = shadow.acc * operand;
            OP_DIV:
            begin
                divisor = $signed(operand);
                if (divisor == 0)
                    return ST_DIV0;
                dividend = $signed(shadow.acc);
                quotient = dividend / divisor;
                shadow.acc = quotient[23:0];
            end
            OP_AND:  shadow.acc = shadow.acc & operand;
            OP_OR:   shadow.acc = shadow.acc | operand;
            OP_COMP: shadow.cc = compare_words(shadow.acc, operand);
            OP_TIX:
            begin
                shadow.x = shadow.x + 24'd1;
                shadow.cc = compare_words(shadow.x, operand);
            end
            OP_J:    shadow.pc = ta;
            OP_JEQ:  if (shadow.cc == CC_EQ) shadow.pc = ta;
            OP_JGT:  if (shadow.cc == CC_GT) shadow.pc = ta;
            OP_JLT:  if (shadow.cc == CC_LT) shadow.pc = ta;
            OP_JSUB:
            begin
                shadow.l = {9'd0, shadow.pc};
                shadow.pc = ta;
            end
            OP_RSUB: shadow.pc = shadow.l[14:0];
            OP_LDA:  shadow.acc = operand;
            OP_LDCH: shadow.acc = {shadow.acc[23:8], shadow_mem[ta]};
            OP_LDL:  shadow.l = operand;
            OP_LDX:  shadow.x = operand;
            OP_STA:  poke_word(ta, shadow.acc);
            OP_STCH: poke(ta, shadow.acc[7:0]);
            OP_STL:  poke_word(ta, shadow.l);
            OP_STSW: poke_word(ta, {22'd0, shadow.cc});
            OP_STX:  poke_word(ta, shadow.x);
            default: return ST_BADOP;
        endcase
        return ST_OK;
    endfunction

    // Queue one request and the register file it should produce
    function automatic void push_request(logic [1:0] cmd, logic [14:0] a, logic [7:0] d);
        request_t r;
        r.cmd = cmd;
        r.addr = a;
        r.data = d;
        shadow.st = ST_OK;
        case (cmd)
            CMD_WRITE: poke(a, d);
            CMD_START:
            begin
                shadow.pc = a;
                shadow.acc = '0;
                shadow.x = '0;
                shadow.l = '0;
                shadow.cc = CC_LT;
            end
            CMD_EXEC:
            begin
                shadow.st = step_instruction();
                exec_cnt++;
            end
            default: ;
        endcase
        request_q.push_back(r);
        expected_q.push_back(shadow);
    endfunction

    function automatic void load_word(logic [14:0] a, logic [23:0] v);
        push_request(CMD_WRITE, a, v[23:16]);
        push_request(CMD_WRITE, a + 15'd1, v[15:8]);
        push_request(CMD_WRITE, a + 15'd2, v[7:0]);
    endfunction

    function automatic logic [23:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 24'h000000;
            1: return 24'h000001;
            2: return 24'hFFFFFF;
            3: return 24'h800000;
            4: return 24'h7FFFFF;
            5: return 24'($urandom_range(0, 40));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_opcode();
        logic [7:0] ops [0:25];
        ops = '{OP_LDA, OP_LDX, OP_LDL, OP_STA, OP_STX, OP_STL, OP_ADD, OP_SUB,
                OP_MUL, OP_DIV, OP_COMP, OP_TIX, OP_JEQ, OP_JGT, OP_JLT, OP_J,
                OP_AND, OP_OR, OP_JSUB, OP_RSUB, OP_LDCH, OP_STCH, OP_STSW,
                OP_RD, OP_TD, OP_WD};
        if ($urandom_range(0, 19) == 0)
            return 8'($urandom);
        return ops[$urandom_range(0, 25)];
    endfunction

    function automatic logic [15:0] pick_field();
        logic [14:0] a;
        case ($urandom_range(0, 19))
            0, 1, 2:    a = 15'h7FF0 + 15'($urandom_range(0, 15));
            3, 4, 5, 6, 7, 8, 9: a = 15'($urandom);
            default:    a = 15'h0100 + 15'($urandom_range(0, 63));
        endcase
        return {($urandom_range(0, 3) == 0), a};
    endfunction

    function automatic bit reads_word(logic [7:0] op);
        return op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_COMP,
                          OP_TIX, OP_LDA, OP_LDL, OP_LDX};
    endfunction

    // Place an instruction at PC, load its operand if needed, then execute it
    function automatic void run_op(logic [7:0] op, logic [15:0] fld, bit fresh,
                                   bit set_operand, logic [23:0] operand);
        logic [14:0] pc, ta;
        logic [14:0] b;
        logic [23:0] fill;
        pc = shadow.pc;
        if (fresh || !mem_loaded[pc] || !mem_loaded[pc + 15'd1] || !mem_loaded[pc + 15'd2])
            load_word(pc, {op, fld});
        op = shadow_mem[pc];
        fld = {shadow_mem[pc + 15'd1], shadow_mem[pc + 15'd2]};
        ta = fld[14:0] + (fld[15] ? shadow.x[14:0] : 15'd0);
        if (set_operand)
            load_word(ta, operand);
        else if (reads_word(op))
        begin
            // Fill only missing bytes so an operand next to the code leaves it intact
            fill = pick_word();
            for (int i = 0; i < 3; i++)
            begin
                b = ta + 15'(i);
                if (!mem_loaded[b])
                    push_request(CMD_WRITE, b, fill[23 - 8*i -: 8]);
            end
        end
        else if (op == OP_LDCH && !mem_loaded[ta])
            push_request(CMD_WRITE, ta, 8'($urandom));
        push_request(CMD_EXEC, 15'($urandom), 8'($urandom));
    endfunction

    function automatic void build_stimulus();
        shadow = '{acc: '0, x: '0, l: '0, pc: '0, cc: CC_EQ, st: ST_OK};
        // Directed: arithmetic corners, divide cases, jumps, subroutine, bytes, devices
        push_request(CMD_NOP, 15'h7FFF, 8'hFF);
        push_request(CMD_START, 15'h0000, 8'h00);
        run_op(OP_LDA,  16'h0100, 1, 1, 24'h7FFFFF);
        run_op(OP_ADD,  16'h0103, 1, 1, 24'h000001);
        run_op(OP_SUB,  16'h0106, 1, 1, 24'h000002);
        run_op(OP_MUL,  16'h0109, 1, 1, 24'hFFFFFF);
        run_op(OP_DIV,  16'h010C, 1, 1, 24'h000000);
        run_op(OP_LDA,  16'h0100, 1, 1, 24'h800000);
        run_op(OP_DIV,  16'h010C, 1, 1, 24'hFFFFFF);
        run_op(OP_COMP, 16'h0103, 1, 1, 24'h000001);
        run_op(OP_LDX,  16'h0106, 1, 1, 24'h7FFFFF);
        run_op(OP_TIX,  16'h0109, 1, 1, 24'h800000);
        run_op(OP_JLT,  16'h0200, 1, 0, '0);
        run_op(OP_JSUB, 16'h0300, 1, 0, '0);
        run_op(OP_STL,  16'h0110, 1, 0, '0);
        run_op(OP_RSUB, 16'h0000, 1, 0, '0);
        run_op(OP_LDCH, 16'h0120, 1, 0, '0);
        run_op(OP_STCH, 16'h7FFF, 1, 0, '0);
        run_op(OP_STSW, 16'h0113, 1, 0, '0);
        run_op(OP_WD,   16'hFFFF, 1, 0, '0);
        push_request(CMD_START, 15'h7FFE, 8'h00);
        run_op(OP_LDX,  16'h0130, 1, 1, 24'h000010);
        run_op(OP_OR,   16'h8120, 1, 1, 24'h0F0F0F);
        run_op(OP_AND,  16'h8120, 1, 0, '0);
        run_op(OP_J,    16'h80F0, 1, 0, '0);
        // Random programs, mostly well-formed, with stray writes and restarts
        while (request_q.size() < RAND_ITEMS) begin
            case ($urandom_range(0, 99))
                0, 1, 2, 3: push_request(CMD_START, 15'($urandom), 8'($urandom));
                4, 5:       push_request(CMD_NOP, 15'($urandom), 8'($urandom));
                6, 7, 8:    push_request(CMD_WRITE, 15'($urandom), 8'($urandom));
                default:
                    run_op(pick_opcode(), pick_field(), $urandom_range(0, 9) < 8, 0, '0);
            endcase
        end
        total_req = request_q.size();
    endfunction

    function automatic int phase_of(int n);
        return (n * 4) / total_req;
    endfunction

    // Driver: present queued requests, hold them while stalled
    always @(posedge clk or negedge rst_n)
    begin
        int nsent;
        int idle_pct;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            nsent = sent_cnt + ((in_valid && !in_stall) ? 1 : 0);
            sent_cnt <= nsent;
            case (phase_of(nsent))
                1:       idle_pct = 84;
                3:       idle_pct = 11;
                default: idle_pct = 0;
            endcase
            if (in_valid && in_stall)
                ;
            else if (nsent < total_req && !(nsent == PAUSE_AT && recv_cnt < nsent) &&
                     $urandom_range(0, 99) >= idle_pct)
            begin
                in_valid  <= 1'b1;
                command   <= request_q[nsent].cmd;
                address   <= request_q[nsent].addr;
                data_byte <= request_q[nsent].data;
            end
            else
                in_valid <= 1'b0;
        end
    end

    task automatic check_field(string name, logic [23:0] exp_v, logic [23:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
        end
    endtask

    // Monitor: compare each result with the oldest expectation, drive stall
    always @(posedge clk or negedge rst_n)
    begin
        core_state_t e;
        int stall_pct;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                recv_cnt <= recv_cnt + 1;
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no request pending, got acc %h pc %h",
                             $time, acc, prog_counter);
                end
                else
                begin
                    e = expected_q.pop_front();
                    check_field("acc", e.acc, acc);
                    check_field("index_reg", e.x, index_reg);
                    check_field("link_reg", e.l, link_reg);
                    check_field("prog_counter", {9'd0, e.pc}, {9'd0, prog_counter});
                    check_field("cond_code", {22'd0, e.cc}, {22'd0, cond_code});
                    check_field("status", {22'd0, e.st}, {22'd0, status});
                end
            end
            case (phase_of(recv_cnt))
                2:       stall_pct = 84;
                3:       stall_pct = 11;
                default: stall_pct = 0;
            endcase
            if (!hold_done && recv_cnt == HOLD_AT)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Watchdog: stop when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        build_stimulus();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait (recv_cnt == total_req);
        repeat (60) @(posedge clk);
        if (expected_q.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results never arrived", $time, expected_q.size());
        end
        $display("Covered %0d requests, %0d instruction executions, over four idle/stall mixes",
                 total_req, exec_cnt);
        $display("including a long output hold and a drain pause; %0d mismatches", errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
